// File: sv/scba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the size-class block allocator.
// No dependencies; every other file of the block imports this package.
package scba_pkg;

  localparam int BLOCK_UNIT   = 16;
  localparam int SIZE_CLASSES = 8;
  localparam int CHUNK_BYTES  = 16 * 1024;
  localparam int POOL_CHUNKS  = 16;

  localparam int OP_W     = 2;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 18;
  localparam int STATUS_W = 2;
  localparam int LIVE_W   = 15;
  localparam int CHUNK_W  = 5;

  localparam int CLS_W      = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int MAX_BLOCK  = BLOCK_UNIT * SIZE_CLASSES;
  localparam int LEFT_W     = $clog2(CHUNK_BYTES / BLOCK_UNIT + 1);
  localparam int LINK_DEPTH = (POOL_CHUNKS * CHUNK_BYTES) / BLOCK_UNIT;
  localparam int IDX_W      = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_OVERSIZE  = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  // Free-list head or link: a valid flag over a block address.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } head_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
  } scba_cmd_t;

endpackage

// File: sv/scba_req_if.sv
`timescale 1ns / 1ps
// Request channel of the allocator: valid/ready handshake with the request payload.
// Depends on scba_pkg for the field widths.
interface scba_req_if;
  import scba_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] block_addr;

  modport source (output valid, output operation, output req_size, output block_addr,
                  input ready);
  modport sink (input valid, input operation, input req_size, input block_addr,
                output ready);
endinterface

// File: sv/scba_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the allocator: valid/ready handshake with the result payload.
// Depends on scba_pkg for the field widths.
interface scba_rsp_if;
  import scba_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   alloc_addr;
  logic [STATUS_W-1:0] status;
  logic [LIVE_W-1:0]   live_blocks;
  logic [CHUNK_W-1:0]  chunks_used;

  modport source (output valid, output alloc_addr, output status, output live_blocks,
                  output chunks_used, input ready);
  modport sink (input valid, input alloc_addr, input status, input live_blocks,
                input chunks_used, output ready);
endinterface

// File: sv/scba_ctrl.sv
`timescale 1ns / 1ps
// Controller of the allocator: sequences accept and execute, owns the result valid flag.
// Depends on scba_pkg for the command struct.
module scba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output scba_pkg::scba_cmd_t cmd
);
  import scba_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE);
  assign cmd.accept = in_valid && in_ready;
  // The request executes only once the result register can take its beat.
  assign cmd.commit = (state == S_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept) state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.commit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_EXEC))
    else $error("accepted request did not move to execute");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed request produced no result beat");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && !out_free) |=> ((state == S_EXEC) && !in_ready))
    else $error("request left execute while the result register was full");

endmodule

// File: sv/scba_dp.sv
`timescale 1ns / 1ps
// Datapath of the allocator: class heads, carving state, counters, link memory, result register.
// Depends on scba_pkg; driven by the accept and commit commands of scba_ctrl.
module scba_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  scba_pkg::scba_cmd_t           cmd,
  input  logic [scba_pkg::OP_W-1:0]     operation,
  input  logic [scba_pkg::SIZE_W-1:0]   req_size,
  input  logic [scba_pkg::ADDR_W-1:0]   block_addr,
  output logic [scba_pkg::ADDR_W-1:0]   alloc_addr,
  output logic [scba_pkg::STATUS_W-1:0] status,
  output logic [scba_pkg::LIVE_W-1:0]   live_blocks,
  output logic [scba_pkg::CHUNK_W-1:0]  chunks_used
);
  import scba_pkg::*;

  function automatic logic [IDX_W-1:0] link_index(logic [ADDR_W-1:0] a);
    return IDX_W'((a / BLOCK_UNIT) % LINK_DEPTH);
  endfunction

  // Per-class constants: block size and blocks per chunk.
  logic [ADDR_W-1:0] bsize_tab [SIZE_CLASSES];
  logic [LEFT_W-1:0] cap_tab   [SIZE_CLASSES];

  for (genvar c = 0; c < SIZE_CLASSES; c++) begin : g_class_const
    localparam int Bsize = BLOCK_UNIT * (c + 1);
    localparam int Cap   = CHUNK_BYTES / Bsize;
    assign bsize_tab[c] = ADDR_W'(Bsize);
    assign cap_tab[c]   = LEFT_W'(Cap);
  end

  // Class state.
  logic              head_valid [SIZE_CLASSES];
  logic [ADDR_W-1:0] head_addr  [SIZE_CLASSES];
  logic [ADDR_W-1:0] carve_addr [SIZE_CLASSES];
  logic [LEFT_W-1:0] carve_left [SIZE_CLASSES];
  logic [LIVE_W-1:0] block_total;
  logic [CHUNK_W-1:0] chunk_total;

  head_t link_mem [LINK_DEPTH];
  head_t link_q;

  // Latched request.
  logic [OP_W-1:0]   r_op;
  logic              r_zero;
  logic              r_over;
  logic [CLS_W-1:0]  r_cls;
  logic [ADDR_W-1:0] r_addr;

  logic [CLS_W-1:0] in_cls;
  logic [IDX_W-1:0] rd_idx;

  assign in_cls = CLS_W'((req_size - SIZE_W'(1)) / BLOCK_UNIT);
  // The link under the current head is fetched as the request is taken, so it
  // is ready when the request executes.
  assign rd_idx = link_index(head_addr[in_cls]);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      r_op   <= operation;
      r_zero <= (req_size == '0);
      r_over <= (req_size > SIZE_W'(MAX_BLOCK));
      r_cls  <= in_cls;
      r_addr <= block_addr;
      link_q <= link_mem[rd_idx];
    end
  end

  // Execute.
  logic              do_clear, do_pop, do_carve, do_chunk, do_push;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;
  logic [ADDR_W-1:0] cls_bsize;
  logic [LEFT_W-1:0] cls_cap;
  logic [ADDR_W-1:0] chunk_base;
  logic              pool_full;
  logic [LIVE_W-1:0] live_next;
  logic [CHUNK_W-1:0] chunk_next;

  assign cls_bsize  = bsize_tab[r_cls];
  assign cls_cap    = cap_tab[r_cls];
  assign chunk_base = ADDR_W'(chunk_total * CHUNK_BYTES);
  assign pool_full  = (chunk_total >= CHUNK_W'(POOL_CHUNKS));

  always_comb begin
    do_clear   = 1'b0;
    do_pop     = 1'b0;
    do_carve   = 1'b0;
    do_chunk   = 1'b0;
    do_push    = 1'b0;
    res_addr   = '0;
    res_status = ST_OK;
    if (r_op == OP_CLEAR) begin
      do_clear = 1'b1;
    end else if ((r_op == OP_ALLOC) || (r_op == OP_FREE)) begin
      if (r_zero) begin
        res_status = ST_ZERO;
      end else if (r_over) begin
        res_status = ST_OVERSIZE;
      end else if (r_op == OP_ALLOC) begin
        if (head_valid[r_cls]) begin
          do_pop   = 1'b1;
          res_addr = head_addr[r_cls];
        end else if (carve_left[r_cls] != '0) begin
          do_carve = 1'b1;
          res_addr = carve_addr[r_cls];
        end else if (pool_full || (cls_cap == '0)) begin
          res_status = ST_EXHAUSTED;
        end else begin
          do_chunk = 1'b1;
          res_addr = chunk_base;
        end
      end else begin
        do_push = 1'b1;
      end
    end
  end

  always_comb begin
    live_next = block_total;
    if (do_clear) begin
      live_next = '0;
    end else if ((do_pop || do_carve || do_chunk) && (block_total != '1)) begin
      live_next = block_total + LIVE_W'(1);
    end else if (do_push && (block_total != '0)) begin
      live_next = block_total - LIVE_W'(1);
    end
    chunk_next = chunk_total;
    if (do_clear) begin
      chunk_next = '0;
    end else if (do_chunk) begin
      chunk_next = chunk_total + CHUNK_W'(1);
    end
  end

  // Control state: valid flags, carve counts and totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < SIZE_CLASSES; c++) begin
        head_valid[c] <= 1'b0;
        carve_left[c] <= '0;
      end
      block_total <= '0;
      chunk_total <= '0;
    end else if (cmd.commit) begin
      block_total <= live_next;
      chunk_total <= chunk_next;
      if (do_clear) begin
        for (int c = 0; c < SIZE_CLASSES; c++) begin
          head_valid[c] <= 1'b0;
          carve_left[c] <= '0;
        end
      end
      if (do_pop) head_valid[r_cls] <= link_q.valid;
      if (do_push) head_valid[r_cls] <= 1'b1;
      if (do_carve) carve_left[r_cls] <= carve_left[r_cls] - LEFT_W'(1);
      if (do_chunk) carve_left[r_cls] <= cls_cap - LEFT_W'(1);
    end
  end

  // Payload state: addresses and the result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_pop) head_addr[r_cls] <= link_q.addr;
      if (do_push) head_addr[r_cls] <= r_addr;
      if (do_carve) carve_addr[r_cls] <= carve_addr[r_cls] + cls_bsize;
      if (do_chunk) carve_addr[r_cls] <= chunk_base + cls_bsize;
      alloc_addr  <= res_addr;
      status      <= res_status;
      live_blocks <= live_next;
      chunks_used <= chunk_next;
    end
  end

  // A freed block links to the head it displaces.
  always_ff @(posedge clk) begin
    if (cmd.commit && do_push) begin
      link_mem[link_index(r_addr)] <= '{valid: head_valid[r_cls], addr: head_addr[r_cls]};
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    chunk_total <= CHUNK_W'(POOL_CHUNKS))
    else $error("more chunks carved than the pool holds");

  a_clear_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && do_clear) |=> ((chunk_total == '0) && (block_total == '0)))
    else $error("clear left a counter nonzero");

  a_fail_no_change: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (res_status == ST_EXHAUSTED)) |=> ($stable(chunk_total) && $stable(block_total)))
    else $error("failed allocation changed the counters");

endmodule

// File: sv/size_class_block_allocator_core.sv
`timescale 1ns / 1ps
// Size-class block allocator: segregated LIFO free lists over a pool of equal chunks.
// Requests enter on req (operation, req_size, block_addr); one result beat per request
// leaves on rsp (alloc_addr, status, live_blocks, chunks_used). Both are valid/ready.
// An allocation pops its class's free list, else carves the class's current chunk,
// else opens the next pool chunk; a free pushes the address onto its class's list.
// A request is taken only while no earlier request waits in execute, so a new request
// is not taken before the last one executes; the link memory read is issued as the request
// is taken and its registered data is used in the execute state that follows.
// A stalled result holds in the output register; meanwhile one more request is taken
// and waits in execute, with no state updated, until the result register frees.
// Reset clears all list heads, carving counts and both totals at once. The link memory
// is not cleared: only links written by a free are ever read.
// Depends on scba_pkg, scba_req_if, scba_rsp_if, scba_ctrl and scba_dp.
module size_class_block_allocator_core (
  input logic        clk,
  input logic        rst,
  scba_req_if.sink   req,
  scba_rsp_if.source rsp
);
  import scba_pkg::*;

  scba_cmd_t cmd;

  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  scba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (req.operation),
    .req_size    (req.req_size),
    .block_addr  (req.block_addr),
    .alloc_addr  (rsp.alloc_addr),
    .status      (rsp.status),
    .live_blocks (rsp.live_blocks),
    .chunks_used (rsp.chunks_used)
  );

endmodule
